// ===== rtl/ils_pkg.sv =====
// Shared types and constants for the indexed list store.
// Used by ils_ctrl, ils_dp and the top level indexed_list_store.
package ils_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int REQ_W     = 3;
  localparam int POS_W     = 8;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int LEN_W     = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ = 3'd0,
    REQ_HEAD = 3'd1,
    REQ_TAIL = 3'd2,
    REQ_AT   = 3'd3,
    REQ_DEL  = 3'd4
  } req_kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_FINISH
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic shift_up;
    logic shift_dn;
    logic put;
    logic shrink;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ok_read;
    logic ok_insert;
    logic ok_delete;
    logic up_more;
    logic dn_more;
  } dp_stat_t;

endpackage

// ===== rtl/ils_ctrl.sv =====
// Controller state machine for the indexed list store.
// Depends on ils_pkg; drives ils_dp through dp_cmd_t and reads dp_stat_t.
module ils_ctrl
  import ils_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.ok_insert) begin
          state_next = S_SHIFT_UP;
        end else if (stat.ok_delete) begin
          state_next = S_SHIFT_DN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT_UP: begin
        if (!stat.up_more) state_next = S_PUT;
      end
      S_PUT: begin
        state_next = S_FINISH;
      end
      S_SHIFT_DN: begin
        if (!stat.dn_more) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
      end
      S_SHIFT_UP: begin
        cmd.shift_up = 1'b1;
      end
      S_PUT: begin
        cmd.put = 1'b1;
      end
      S_SHIFT_DN: begin
        cmd.shift_dn = 1'b1;
        cmd.shrink   = !stat.dn_more;
      end
      S_FINISH: begin
        cmd.out_load = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // The output register is refilled only when its previous beat is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/ils_dp.sv =====
// Datapath of the indexed list store: request registers, element memory,
// element count, shift cursor and result registers. Depends on ils_pkg.
module ils_dp
  import ils_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic        [REQ_W-1:0] req_type,
  input  logic signed [POS_W-1:0] position,
  input  logic signed [VAL_W-1:0] item_value,
  output logic signed [VAL_W-1:0] read_value,
  output logic        [ST_W-1:0]  status,
  output logic        [LEN_W-1:0] length
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;

  logic [VAL_W-1:0] mem [DEPTH];

  logic [REQ_W-1:0] kind;
  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  logic [CW-1:0]    count;
  logic [CW-1:0]    cursor;
  logic [CW-1:0]    ins_at;
  logic [CW-1:0]    target;
  logic [AW-1:0]    waddr;
  logic             wpend;
  logic [VAL_W-1:0] rdata;
  status_t          code;
  status_t          code_q;

  logic             neg;
  logic [CMPW-1:0]  idx_ext;
  logic [CMPW-1:0]  cnt_ext;
  logic             full;
  logic             rng_rd;
  logic             rng_ins;
  logic             ok_rd;
  logic             ok_ins;
  logic             ok_del;
  logic             step_up;
  logic             step_dn;

  logic             re;
  logic [AW-1:0]    ra;
  logic             we;
  logic [AW-1:0]    wa;
  logic [VAL_W-1:0] wd;

  assign neg     = pos[POS_W-1];
  assign idx_ext = CMPW'(pos[POS_W-2:0]);
  assign cnt_ext = CMPW'(count);
  assign full    = (count == CW'(DEPTH));
  assign rng_rd  = !neg && (idx_ext < cnt_ext);
  assign rng_ins = !neg && (idx_ext <= cnt_ext);

  always_comb begin
    code   = ST_RANGE;
    ok_rd  = 1'b0;
    ok_ins = 1'b0;
    ok_del = 1'b0;
    target = '0;
    case (kind)
      REQ_READ: begin
        if (rng_rd) begin
          code  = ST_DONE;
          ok_rd = 1'b1;
        end
      end
      REQ_HEAD, REQ_TAIL: begin
        target = (kind == REQ_TAIL) ? count : '0;
        if (full) begin
          code = ST_FULL;
        end else begin
          code   = ST_DONE;
          ok_ins = 1'b1;
        end
      end
      REQ_AT: begin
        target = idx_ext[CW-1:0];
        if (!rng_ins) begin
          code = ST_RANGE;
        end else if (full) begin
          code = ST_FULL;
        end else begin
          code   = ST_DONE;
          ok_ins = 1'b1;
        end
      end
      REQ_DEL: begin
        if (rng_rd) begin
          code   = ST_DONE;
          ok_del = 1'b1;
        end
      end
      default: begin
        code = ST_RANGE;
      end
    endcase
  end

  assign stat.ok_read   = ok_rd;
  assign stat.ok_insert = ok_ins;
  assign stat.ok_delete = ok_del;
  assign stat.up_more   = (cursor > ins_at);
  assign stat.dn_more   = ((cursor + CW'(1)) < count);

  assign step_up = cmd.shift_up && stat.up_more;
  assign step_dn = cmd.shift_dn && stat.dn_more;

  // An insert moves entries up starting from the tail; a delete moves them
  // down starting from the hole. Each move reads one entry and writes it
  // in the next cycle, so a read and the previous move's write share a cycle.
  always_comb begin
    re = 1'b0;
    ra = '0;
    if (cmd.decode && ok_rd) begin
      re = 1'b1;
      ra = idx_ext[AW-1:0];
    end else if (step_up) begin
      re = 1'b1;
      ra = cursor[AW-1:0] - AW'(1);
    end else if (step_dn) begin
      re = 1'b1;
      ra = cursor[AW-1:0] + AW'(1);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (wpend) begin
      we = 1'b1;
      wa = waddr;
      wd = rdata;
    end else if (cmd.put) begin
      we = 1'b1;
      wa = ins_at[AW-1:0];
      wd = val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wpend <= 1'b0;
    end else begin
      wpend <= step_up || step_dn;
      if (cmd.put) begin
        count <= count + CW'(1);
      end else if (cmd.shrink) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_type;
      pos  <= position;
      val  <= item_value;
    end
    if (cmd.decode) begin
      code_q <= code;
      cursor <= ok_ins ? count : idx_ext[CW-1:0];
      ins_at <= target;
    end else if (step_up) begin
      cursor <= cursor - CW'(1);
    end else if (step_dn) begin
      cursor <= cursor + CW'(1);
    end
    waddr <= cursor[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (kind == REQ_READ) begin
        read_value <= (code_q == ST_DONE) ? rdata : '1;
      end else begin
        read_value <= '0;
      end
      status <= code_q;
      length <= cnt_ext[LEN_W-1:0];
    end
  end

  a_put_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> count != CW'(DEPTH))
    else $error("insert committed into a full store");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(wpend && cmd.put))
    else $error("shift write and insert write in the same cycle");

  a_put_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.put |=> count == $past(count) + CW'(1))
    else $error("count did not grow after an insert");

  a_shrink_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.shrink |-> count != '0)
    else $error("delete from an empty store");

endmodule

// ===== rtl/indexed_list_store.sv =====
// Indexed list store: an ordered list of signed 32-bit values of bounded depth.
// Requests come in on the input channel and each gives one result beat on the
// output channel. Both channels use valid/ready; a beat moves when both are high.
// A request reads at an index, inserts at the head, appends at the tail, inserts
// before an index, or deletes at an index. Each result carries the read value
// (-1 on a read out of range, else zero for writes), a status (done, out of
// range, full) and the list length after the request.
// One request is handled at a time. After accept, a request is decoded; an insert
// then moves the entries from the index to the tail up by one (length minus index
// entries) and writes the new value, and a delete moves the entries above the index
// down by one (length minus index minus one entries). The element memory reads one
// entry and writes one entry each cycle while entries move, then the result register
// is loaded. With a ready receiver the next request is accepted at the edge that
// takes the result beat.
// The next request is accepted while the previous result still waits; if the
// receiver stalls, the block holds its finished result and waits before
// overwriting the output register.
// Reset empties the list at once; element memory contents are not cleared.
// Depends on ils_pkg, ils_ctrl and ils_dp.
module indexed_list_store
  import ils_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic        [REQ_W-1:0] req_type,
  input  logic signed [POS_W-1:0] position,
  input  logic signed [VAL_W-1:0] item_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] read_value,
  output logic        [ST_W-1:0]  status,
  output logic        [LEN_W-1:0] length
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ils_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .position   (position),
    .item_value (item_value),
    .read_value (read_value),
    .status     (status),
    .length     (length)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for indexed_list_store: directed corner requests, then random
// bursts that grow, shrink and churn the list, checked beat by beat against a scoreboard.
// Depends on ils_pkg and the indexed_list_store RTL.
module tb;
  import ils_pkg::*;

  localparam int CYCLE_LIMIT = 600_000;
  localparam int PHASE_ITEMS = 550;

  typedef enum int {GROW, SHRINK, CHURN} mix_t;

  class list_scoreboard;
    typedef struct {
      logic signed [VAL_W-1:0] rd;
      status_t                 st;
      logic        [LEN_W-1:0] len;
    } outcome_t;

    logic signed [VAL_W-1:0] elems [DEPTH_DEF];
    int unsigned held;
    outcome_t    awaiting [$];
    int          errors;
    int          requests;
    int          checked;
    int          full_refusals;
    int          range_refusals;
    int unsigned peak;

    function int pending();
      return awaiting.size();
    endfunction

    // Applies one accepted request to the shadow list and queues the result it must give.
    function status_t note_request(input logic [REQ_W-1:0] kind,
                                   input logic [POS_W-1:0] pos,
                                   input logic signed [VAL_W-1:0] val);
      outcome_t    o;
      logic        neg;
      int unsigned idx;
      int unsigned at;
      int unsigned k;
      neg  = pos[POS_W-1];
      idx  = pos[POS_W-2:0];
      o.rd = '0;
      o.st = ST_DONE;
      at   = DEPTH_DEF;
      case (kind)
        REQ_READ: begin
          if (neg || idx >= held) begin
            o.rd = -1;
            o.st = ST_RANGE;
          end else begin
            o.rd = elems[idx];
          end
        end
        REQ_HEAD: begin
          if (held >= DEPTH_DEF) o.st = ST_FULL;
          else at = 0;
        end
        REQ_TAIL: begin
          if (held >= DEPTH_DEF) o.st = ST_FULL;
          else at = held;
        end
        REQ_AT: begin
          // The range check wins over the full check.
          if (neg || idx > held) o.st = ST_RANGE;
          else if (held >= DEPTH_DEF) o.st = ST_FULL;
          else at = idx;
        end
        REQ_DEL: begin
          if (neg || idx >= held) begin
            o.st = ST_RANGE;
          end else begin
            for (k = idx; k + 1 < held; k++) elems[k] = elems[k+1];
            held--;
          end
        end
        default: o.st = ST_RANGE;
      endcase
      if (at < DEPTH_DEF) begin
        for (k = held; k > at; k--) elems[k] = elems[k-1];
        elems[at] = val;
        held++;
      end
      o.len = held[LEN_W-1:0];
      if (held > peak) peak = held;
      if (o.st == ST_FULL) full_refusals++;
      if (o.st == ST_RANGE) range_refusals++;
      requests++;
      awaiting.push_back(o);
      return o.st;
    endfunction

    function void check_result(input logic signed [VAL_W-1:0] rd,
                               input logic [ST_W-1:0] st,
                               input logic [LEN_W-1:0] len);
      outcome_t o;
      if (awaiting.size() == 0) begin
        errors++;
        if (errors < 100)
          $display("%0t: result beat with nothing outstanding (value %0d status %0d length %0d)",
                   $time, rd, st, len);
        return;
      end
      o = awaiting.pop_front();
      checked++;
      if (rd !== o.rd) begin
        errors++;
        if (errors < 100)
          $display("%0t: read_value expected %0d actual %0d", $time, o.rd, rd);
      end
      if (st !== o.st) begin
        errors++;
        if (errors < 100)
          $display("%0t: status expected %0d actual %0d", $time, o.st, st);
      end
      if (len !== o.len) begin
        errors++;
        if (errors < 100)
          $display("%0t: length expected %0d actual %0d", $time, o.len, len);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic        [REQ_W-1:0] req_type;
  logic signed [POS_W-1:0] position;
  logic signed [VAL_W-1:0] item_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] read_value;
  logic        [ST_W-1:0]  status;
  logic        [LEN_W-1:0] length;

  list_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int cycles;

  indexed_list_store dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .position  (position),
    .item_value(item_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_value(read_value),
    .status    (status),
    .length    (length)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Handshake signals are sampled just after the edge, so they hold their pre-edge values.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(read_value, status, length);
  end

  // Presents one request, holds it until the beat is taken, then records it.
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val,
                              output status_t verdict);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    position   <= pos;
    item_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdict = sb.note_request(kind, pos, val);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [REQ_W-1:0] pick_kind(input mix_t mix);
    int r;
    r = $urandom_range(99, 0);
    if (r < 3) return REQ_W'($urandom_range(2**REQ_W - 1, int'(REQ_DEL) + 1));
    case (mix)
      GROW: begin
        if (r < 13) return REQ_READ;
        if (r < 38) return REQ_HEAD;
        if (r < 66) return REQ_TAIL;
        if (r < 96) return REQ_AT;
        return REQ_DEL;
      end
      SHRINK: begin
        if (r < 18) return REQ_READ;
        if (r < 23) return REQ_HEAD;
        if (r < 28) return REQ_TAIL;
        if (r < 35) return REQ_AT;
        return REQ_DEL;
      end
      default: begin
        if (r < 28) return REQ_READ;
        if (r < 43) return REQ_HEAD;
        if (r < 58) return REQ_TAIL;
        if (r < 78) return REQ_AT;
        return REQ_DEL;
      end
    endcase
  endfunction

  // Mostly indexes inside the list, with the length itself, far indexes and negatives mixed in.
  function automatic logic [POS_W-1:0] pick_position(input int unsigned held);
    int r;
    r = $urandom_range(99, 0);
    if (r < 7) return {1'b1, (POS_W-1)'($urandom)};
    if (r < 15) return POS_W'($urandom_range(2**(POS_W-1) - 1, 0));
    if (r < 25 || held == 0) return POS_W'(held);
    return POS_W'($urandom_range(held - 1, 0));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(99, 0) < 10) begin
      case ($urandom_range(3, 0))
        0:       return 32'sh7FFFFFFF;
        1:       return 32'sh80000000;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    status_t          verdict;
    logic [REQ_W-1:0] kind;
    mix_t             mix;
    int               phase;
    int               done_items;
    int               burst;
    int               k;
    clk           = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    out_ready     = 1'b0;
    req_type      = REQ_READ;
    position      = '0;
    item_value    = '0;
    cycles        = 0;
    send_idle_pct = 36;
    recv_idle_pct = 62;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty list, both ends, the middle, index equal to length, and out-of-range indexes.
    send_request(REQ_READ, 8'sd0, 32'sd0, verdict);
    send_request(REQ_DEL, 8'sd0, 32'sd0, verdict);
    send_request(REQ_AT, 8'sd0, 32'sh7FFFFFFF, verdict);
    send_request(REQ_HEAD, 8'sd0, 32'sh80000000, verdict);
    send_request(REQ_TAIL, 8'sd0, -32'sd1, verdict);
    send_request(REQ_TAIL, 8'sh7F, 32'sd0, verdict);
    send_request(REQ_AT, 8'sd2, 32'sh55555555, verdict);
    send_request(REQ_AT, 8'sd5, 32'shAAAAAAAA, verdict);
    send_request(REQ_AT, 8'sd7, 32'sd1, verdict);
    send_request(REQ_AT, 8'shFF, 32'sd2, verdict);
    send_request(REQ_AT, 8'sh80, 32'sd3, verdict);
    send_request(REQ_READ, 8'sd0, 32'sd0, verdict);
    send_request(REQ_READ, 8'sd5, 32'sd0, verdict);
    send_request(REQ_READ, 8'sd6, 32'sd0, verdict);
    send_request(REQ_READ, 8'sh7F, 32'sd0, verdict);
    send_request(REQ_READ, 8'shFF, 32'sd0, verdict);
    send_request(REQ_DEL, 8'sd2, 32'sd0, verdict);
    send_request(REQ_DEL, 8'sd0, 32'sd0, verdict);
    send_request(REQ_DEL, 8'sd3, 32'sd0, verdict);
    send_request(REQ_DEL, 8'sh80, 32'sd0, verdict);
    send_request(REQ_DEL, 8'sh7F, 32'sd0, verdict);
    send_request(REQ_W'(int'(REQ_DEL) + 1), 8'sd0, 32'sd9, verdict);
    send_request(REQ_W'(2**REQ_W - 2), 8'sd1, 32'sd9, verdict);
    send_request(REQ_W'(2**REQ_W - 1), 8'shFF, -32'sd1, verdict);

    // Bursts biased toward growth, shrinkage or churn push the list toward full and back toward empty.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 36 : 0;
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        mix   = mix_t'($urandom_range(2, 0));
        burst = $urandom_range(120, 30);
        for (k = 0; k < burst && done_items < PHASE_ITEMS; k++) begin
          kind = pick_kind(mix);
          send_request(kind, pick_position(sb.held), pick_value(), verdict);
          done_items++;
        end
      end
      // Let the block run completely dry before the next idle pattern.
      wait_drained();
    end

    repeat (DEPTH_DEF + 8) @(posedge clk);
    $display("Sent %0d requests and checked %0d result beats; the list peaked at %0d entries.",
             sb.requests, sb.checked, sb.peak);
    $display("Refused %0d inserts on a full list and %0d out-of-range or unknown requests.",
             sb.full_refusals, sb.range_refusals);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/ils_pkg.sv
rtl/ils_ctrl.sv
rtl/ils_dp.sv
rtl/indexed_list_store.sv
verif/tb.sv
